// File: hw/rtl/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// Shared constants, codes and controller/datapath handshake types for the
// integer matrix multiply block.
// ----------------------------------------------------------------------------
package imm_pkg;

   // default sizing handed to the top level parameters
   localparam int MAX_DIM_DEF    = 16;
   localparam int ELEM_WIDTH_DEF = 8;

   // fixed field widths
   localparam int OP_W       = 2;
   localparam int SUM_W      = 32;
   localparam int IDX_OUT_W  = 4;
   localparam int DIM_REG_W  = 5;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // dimension register reset value
   localparam logic [DIM_REG_W-1:0] DIM_RESET = 5'd16;

   // request op codes
   localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   // register indexes (byte address / 4)
   localparam logic [1:0] REG_ROWS_A    = 2'd0;
   localparam logic [1:0] REG_COLS_B    = 2'd1;
   localparam logic [1:0] REG_INNER_LEN = 2'd2;

   // commands from controller to datapath
   typedef struct packed {
      logic load_a;
      logic load_b;
      logic start_read;
      logic issue;
      logic load_out;
   } imm_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic last_step;
   } imm_status_type;

endpackage

// File: hw/rtl/imm_req_if.sv
// ----------------------------------------------------------------------------
// imm_req_if
// Request channel: load an A or B element, or ask for the next result.
// ----------------------------------------------------------------------------
interface imm_req_if import imm_pkg::*; #(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) ();
   logic                         valid;
   logic                         ready;
   logic [OP_W-1:0]              op;
   logic signed [ELEM_WIDTH-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

// File: hw/rtl/imm_rsp_if.sv
// ----------------------------------------------------------------------------
// imm_rsp_if
// Result channel: one element of the product matrix per transfer.
// ----------------------------------------------------------------------------
interface imm_rsp_if import imm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [SUM_W-1:0] sum;
   logic [IDX_OUT_W-1:0]    row_index;
   logic [IDX_OUT_W-1:0]    col_index;
   logic                    last;

   modport source (output valid, output sum, output row_index, output col_index,
                   output last, input ready);
   modport sink   (input valid, input sum, input row_index, input col_index,
                   input last, output ready);
endinterface

// File: hw/rtl/imm_ram.sv
// ----------------------------------------------------------------------------
// imm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module imm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/imm_csr.sv
// ----------------------------------------------------------------------------
// imm_csr
// APB-style register file for the three matrix dimensions, with the
// dimensions clamped to the range 1 .. MAX_DIM for the datapath.
// ----------------------------------------------------------------------------
module imm_csr import imm_pkg::*; #(
   parameter int MAX_DIM = MAX_DIM_DEF,
   localparam int CNT_W = $clog2(MAX_DIM + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [CNT_W-1:0]      dim_m,
   output logic [CNT_W-1:0]      dim_n,
   output logic [CNT_W-1:0]      dim_k
);

   localparam int CMP_W = (CNT_W > DIM_REG_W) ? CNT_W : DIM_REG_W;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_DIM);

   logic [DIM_REG_W-1:0] rows_a_ff, rows_a_in;
   logic [DIM_REG_W-1:0] cols_b_ff, cols_b_in;
   logic [DIM_REG_W-1:0] inner_len_ff, inner_len_in;
   logic                 wr_en;
   logic [1:0]           reg_idx;

   // zero acts as one, anything above the maximum acts as the maximum
   function automatic logic [CNT_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] d);
      logic [CMP_W-1:0] dw;
      dw = CMP_W'(d);
      if (dw == '0) begin
         clamp_dim = CNT_W'(1);
      end else if (dw > MAX_CMP) begin
         clamp_dim = CNT_W'(MAX_DIM);
      end else begin
         clamp_dim = CNT_W'(dw);
      end
   endfunction

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   // register write decode
   always_comb begin
      rows_a_in    = rows_a_ff;
      cols_b_in    = cols_b_ff;
      inner_len_in = inner_len_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_ROWS_A:    rows_a_in    = pwdata[DIM_REG_W-1:0];
            REG_COLS_B:    cols_b_in    = pwdata[DIM_REG_W-1:0];
            REG_INNER_LEN: inner_len_in = pwdata[DIM_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_RESET;
         cols_b_ff    <= DIM_RESET;
         inner_len_ff <= DIM_RESET;
      end else begin
         rows_a_ff    <= rows_a_in;
         cols_b_ff    <= cols_b_in;
         inner_len_ff <= inner_len_in;
      end
   end

   // read back
   always_comb begin
      unique case (reg_idx)
         REG_ROWS_A:    prdata = CSR_DATA_W'(rows_a_ff);
         REG_COLS_B:    prdata = CSR_DATA_W'(cols_b_ff);
         REG_INNER_LEN: prdata = CSR_DATA_W'(inner_len_ff);
         default:       prdata = '0;
      endcase
   end

   assign dim_m = clamp_dim(rows_a_ff);
   assign dim_n = clamp_dim(cols_b_ff);
   assign dim_k = clamp_dim(inner_len_ff);

endmodule

// File: hw/rtl/imm_ctrl.sv
// ----------------------------------------------------------------------------
// imm_ctrl
// Controller: request handshake, dot product sequencing and the result
// register valid flag.
// ----------------------------------------------------------------------------
module imm_ctrl import imm_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_op,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  imm_status_type  status,
   output imm_cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_RUN       = 3'd1;
   localparam logic [2:0] ST_DRAIN_RD  = 3'd2;
   localparam logic [2:0] ST_DRAIN_MUL = 3'd3;
   localparam logic [2:0] ST_DONE      = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // commands
   assign cmd.load_a     = accept && (req_op == OP_LOAD_A);
   assign cmd.load_b     = accept && (req_op == OP_LOAD_B);
   assign cmd.start_read = accept && (req_op == OP_READ);
   assign cmd.issue      = (state_ff == ST_RUN);
   assign cmd.load_out   = (state_ff == ST_DONE) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (cmd.start_read) state_in = ST_RUN;
         ST_RUN:       if (status.last_step) state_in = ST_DRAIN_RD;
         ST_DRAIN_RD:  state_in = ST_DRAIN_MUL;
         ST_DRAIN_MUL: state_in = ST_DONE;
         ST_DONE:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // result register valid flag
   always_comb begin
      priority if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hw/rtl/imm_dp.sv
// ----------------------------------------------------------------------------
// imm_dp
// Datapath: A and B element stores, load counters, result position, the
// read / multiply / accumulate pipeline and the result register.
// ----------------------------------------------------------------------------
module imm_dp import imm_pkg::*; #(
   parameter int MAX_DIM    = MAX_DIM_DEF,
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
   localparam int CNT_W = $clog2(MAX_DIM + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  imm_cmd_type                  cmd,
   output imm_status_type               status,
   input  logic [CNT_W-1:0]             dim_m,
   input  logic [CNT_W-1:0]             dim_n,
   input  logic [CNT_W-1:0]             dim_k,
   input  logic signed [ELEM_WIDTH-1:0] req_value,
   output logic signed [SUM_W-1:0]      rsp_sum,
   output logic [IDX_OUT_W-1:0]         rsp_row_index,
   output logic [IDX_OUT_W-1:0]         rsp_col_index,
   output logic                         rsp_last
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int SIZE_W = $clog2(DEPTH + 1);
   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int PROD_W = 2 * ELEM_WIDTH;

   // store sizes
   logic [2*CNT_W-1:0] a_size_full, b_size_full;
   logic [SIZE_W-1:0]  a_size, b_size;

   // load counters
   logic [SIZE_W-1:0] a_fill_ff, a_fill_in, a_pos, a_next;
   logic [SIZE_W-1:0] b_fill_ff, b_fill_in, b_pos, b_next;

   // result position
   logic [IDX_W-1:0] out_row_ff, out_row_in;
   logic [IDX_W-1:0] out_col_ff, out_col_in;
   logic [CNT_W-1:0] eff_row, eff_col, row_inc, col_inc;
   logic             pos_reset;

   // current read
   logic [ADDR_W-1:0]    a_addr_ff, a_addr_in;
   logic [ADDR_W-1:0]    b_addr_ff, b_addr_in;
   logic [IDX_W-1:0]     step_ff, step_in;
   logic [IDX_OUT_W-1:0] cur_row_ff, cur_col_ff;
   logic                 cur_last_ff;

   // pipeline
   logic [ELEM_WIDTH-1:0]    a_rd, b_rd;
   logic                     rd_v_ff, mul_v_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  acc_ff;

   // result register
   logic signed [SUM_W-1:0] sum_ff;
   logic [IDX_OUT_W-1:0]    row_out_ff, col_out_ff;
   logic                    last_out_ff;

   // element stores
   imm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_a_ram (
      .clock   (clock),
      .wr_en   (cmd.load_a),
      .wr_addr (a_pos[ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_addr (a_addr_ff),
      .rd_data (a_rd)
   );

   imm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_b_ram (
      .clock   (clock),
      .wr_en   (cmd.load_b),
      .wr_addr (b_pos[ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_addr (b_addr_ff),
      .rd_data (b_rd)
   );

   // matrix sizes in elements
   assign a_size_full = {{CNT_W{1'b0}}, dim_m} * {{CNT_W{1'b0}}, dim_k};
   assign b_size_full = {{CNT_W{1'b0}}, dim_k} * {{CNT_W{1'b0}}, dim_n};
   assign a_size      = a_size_full[SIZE_W-1:0];
   assign b_size      = b_size_full[SIZE_W-1:0];

   // load counters, restarting at zero when out of range and after the last element
   always_comb begin
      a_pos  = (a_fill_ff >= a_size) ? '0 : a_fill_ff;
      a_next = a_pos + SIZE_W'(1);
      b_pos  = (b_fill_ff >= b_size) ? '0 : b_fill_ff;
      b_next = b_pos + SIZE_W'(1);
      a_fill_in = a_fill_ff;
      b_fill_in = b_fill_ff;
      if (cmd.load_a) begin
         a_fill_in = (a_next >= a_size) ? '0 : a_next;
      end
      if (cmd.load_b) begin
         b_fill_in = (b_next >= b_size) ? '0 : b_next;
      end
   end

   // effective result position and the one after it
   always_comb begin
      pos_reset = (CNT_W'(out_row_ff) >= dim_m) || (CNT_W'(out_col_ff) >= dim_n);
      eff_row   = pos_reset ? '0 : CNT_W'(out_row_ff);
      eff_col   = pos_reset ? '0 : CNT_W'(out_col_ff);
      row_inc   = eff_row + CNT_W'(1);
      col_inc   = eff_col + CNT_W'(1);
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      if (cmd.start_read) begin
         if (col_inc >= dim_n) begin
            out_col_in = '0;
            out_row_in = (row_inc >= dim_m) ? '0 : IDX_W'(row_inc);
         end else begin
            out_col_in = IDX_W'(col_inc);
            out_row_in = IDX_W'(eff_row);
         end
      end
   end

   // read address walk: along a row of A, down a column of B
   always_comb begin
      a_addr_in = a_addr_ff;
      b_addr_in = b_addr_ff;
      step_in   = step_ff;
      priority if (cmd.start_read) begin
         a_addr_in = ADDR_W'(eff_row) * ADDR_W'(dim_k);
         b_addr_in = ADDR_W'(eff_col);
         step_in   = '0;
      end else if (cmd.issue) begin
         a_addr_in = a_addr_ff + ADDR_W'(1);
         b_addr_in = b_addr_ff + ADDR_W'(dim_n);
         step_in   = step_ff + IDX_W'(1);
      end else begin
         a_addr_in = a_addr_ff;
      end
   end

   assign status.last_step = (CNT_W'(step_ff) == (dim_k - CNT_W'(1)));

   // control and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_fill_ff  <= '0;
         b_fill_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         rd_v_ff    <= 1'b0;
         mul_v_ff   <= 1'b0;
      end else begin
         a_fill_ff  <= a_fill_in;
         b_fill_ff  <= b_fill_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         rd_v_ff    <= cmd.issue;
         mul_v_ff   <= rd_v_ff;
      end
   end

   // address walk and read tags
   always_ff @(posedge clock) begin
      a_addr_ff <= a_addr_in;
      b_addr_ff <= b_addr_in;
      step_ff   <= step_in;
      if (cmd.start_read) begin
         cur_row_ff  <= IDX_OUT_W'(eff_row);
         cur_col_ff  <= IDX_OUT_W'(eff_col);
         cur_last_ff <= (eff_row == dim_m - CNT_W'(1)) && (eff_col == dim_n - CNT_W'(1));
      end
   end

   // multiply stage
   always_ff @(posedge clock) begin
      if (rd_v_ff) begin
         prod_ff <= $signed(a_rd) * $signed(b_rd);
      end
   end

   // accumulate stage, wrapping at 32 bits
   always_ff @(posedge clock) begin
      if (cmd.start_read) begin
         acc_ff <= '0;
      end else if (mul_v_ff) begin
         acc_ff <= acc_ff + SUM_W'(prod_ff);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         sum_ff      <= acc_ff;
         row_out_ff  <= cur_row_ff;
         col_out_ff  <= cur_col_ff;
         last_out_ff <= cur_last_ff;
      end
   end

   assign rsp_sum       = sum_ff;
   assign rsp_row_index = row_out_ff;
   assign rsp_col_index = col_out_ff;
   assign rsp_last      = last_out_ff;

endmodule

// File: hw/rtl/int_matrix_multiply.sv
// ----------------------------------------------------------------------------
// int_matrix_multiply
// Signed integer matrix multiply C = A x B with 32-bit wrapping accumulation.
// ----------------------------------------------------------------------------
// Usage:
//  - req_bus carries op and value. op 0 loads the next element of A, op 1
//    the next element of B, both in row-major order; op 2 asks for the next
//    element of C in row-major order; op 3 is taken and ignored.
//  - rsp_bus returns one transfer per op 2: the wrapped dot product, its row
//    and column, and last on element (M-1, N-1).
//  - M, N and K are set through the APB port at byte addresses 0, 4 and 8;
//    the user must write them only while the block is idle (unchecked);
//    0 is 1, over MAX_DIM is MAX_DIM; writes move no load or read position.
//  - Loads may follow each other every cycle while no read is in progress.
//  - A read walks K products through one multiplier: the request is taken,
//    K store reads are issued, the read and multiply stages drain and the
//    result register is loaded, and only then is the next request taken.
//  - The result register holds the payload while rsp_bus.ready is low; the
//    block still takes loads, and a following read waits at its end.
//  - Synchronous reset sets M, N, K to 16 and clears all positions; the
//    element stores are not cleared and must be loaded before reads.
// ----------------------------------------------------------------------------
module int_matrix_multiply import imm_pkg::*; #(
   parameter int MAX_DIM    = MAX_DIM_DEF,
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   imm_req_if.sink               req_bus,
   imm_rsp_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int CNT_W = $clog2(MAX_DIM + 1);

   imm_cmd_type      cmd;
   imm_status_type   status;
   logic [CNT_W-1:0] dim_m, dim_n, dim_k;

   // dimension registers
   imm_csr #(.MAX_DIM(MAX_DIM)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .dim_m   (dim_m),
      .dim_n   (dim_n),
      .dim_k   (dim_k)
   );

   // controller
   imm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.op),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   imm_dp #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .dim_m         (dim_m),
      .dim_n         (dim_n),
      .dim_k         (dim_k),
      .req_value     (req_bus.value),
      .rsp_sum       (rsp_bus.sum),
      .rsp_row_index (rsp_bus.row_index),
      .rsp_col_index (rsp_bus.col_index),
      .rsp_last      (rsp_bus.last)
   );

`ifndef SYNTHESIS
   // a read transfer blocks the request side on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && (req_bus.op == OP_READ)) |=> !req_bus.ready)
      else $error("request taken while a read is in progress");

   // loads never raise a result
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && !rsp_bus.valid &&
       ((req_bus.op == OP_LOAD_A) || (req_bus.op == OP_LOAD_B))) |=> !rsp_bus.valid)
      else $error("result raised by a load");

   // at most one datapath command per cycle
   assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("conflicting datapath commands");
`endif

endmodule
